// ===== hdl/gfr_pkg.sv =====
// Shared types and constants for the gamepad frame receiver.
// No dependencies; used by every module of the block.
package gfr_pkg;

  localparam int STORE_BYTES = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0]  SOF_BYTE      = 8'hFD;
  localparam logic [3:0]  HDR_NIBBLE    = 4'h4;
  localparam logic [11:0] FRAME_TAG     = 12'hFD4;
  localparam logic [63:0] NEUTRAL_FRAME = 64'hFD40_0000_8080_8080;
  localparam logic [15:0] ERR_MAX       = 16'hFFFF;

  localparam int OUT_DATA_BITS = 136;

  // one finished frame handed from the front to the back
  typedef struct packed {
    logic [63:0] raw_frame;
    logic [15:0] error_tally;
  } frame_item_t;

endpackage

// ===== hdl/gfr_front.sv =====
// Front part: byte classification, frame store and error counter.
// Depends on gfr_pkg; pushes finished frames into gfr_queue.
module gfr_front #(
  parameter int FRAME_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 byte_valid,
  input  logic [7:0]           rx_byte,
  output logic                 push,
  output gfr_pkg::frame_item_t push_item
);

  localparam int FW = $clog2(FRAME_BYTES + 1);
  localparam logic [FW-1:0] FILL_MAX = FW'(FRAME_BYTES);
  localparam logic [FW-1:0] FILL_HDR = FW'(2);

  logic          receiving_r, receiving_nxt;
  logic          start_seen_r, start_seen_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [15:0]   err_r, err_nxt;
  logic [7:0]    store_r [gfr_pkg::STORE_BYTES];
  logic [2:0]    slot;
  logic          good_hdr, store_wr;
  logic [15:0]   err_inc;

  assign slot    = 3'd7 - 3'(fill_r);
  assign err_inc = (err_r == gfr_pkg::ERR_MAX) ? err_r : err_r + 16'd1;

  always_comb begin
    receiving_nxt  = receiving_r;
    start_seen_nxt = start_seen_r;
    fill_nxt       = fill_r;
    err_nxt        = err_r;
    good_hdr       = 1'b0;
    store_wr       = 1'b0;
    push           = 1'b0;
    if (byte_valid) begin
      if (start_seen_r) begin
        start_seen_nxt = 1'b0;
        if (rx_byte[7:4] == gfr_pkg::HDR_NIBBLE) begin
          good_hdr      = 1'b1;
          err_nxt       = '0;
          fill_nxt      = FILL_HDR;
          receiving_nxt = 1'b1;
        end else begin
          err_nxt       = err_inc;
          fill_nxt      = '0;
          receiving_nxt = 1'b0;
        end
      end else begin
        start_seen_nxt = (rx_byte == gfr_pkg::SOF_BYTE);
        if (receiving_r) begin
          if (rx_byte == gfr_pkg::SOF_BYTE) begin
            receiving_nxt = 1'b0;
            push          = 1'b1;
          end else if (fill_r >= FILL_MAX) begin
            err_nxt       = err_inc;
            receiving_nxt = 1'b0;
          end else begin
            store_wr = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < gfr_pkg::STORE_BYTES; i++) begin
      push_item.raw_frame[8*i +: 8] = store_r[i];
    end
    push_item.error_tally = err_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r  <= 1'b0;
      start_seen_r <= 1'b0;
      fill_r       <= '0;
      err_r        <= '0;
      for (int i = 0; i < gfr_pkg::STORE_BYTES; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      receiving_r  <= receiving_nxt;
      start_seen_r <= start_seen_nxt;
      fill_r       <= fill_nxt;
      err_r        <= err_nxt;
      if (good_hdr) begin
        store_r[7] <= gfr_pkg::SOF_BYTE;
        store_r[6] <= rx_byte;
      end else if (store_wr) begin
        store_r[slot] <= rx_byte;
      end
    end
  end

endmodule

// ===== hdl/gfr_queue.sv =====
// Short frame queue between the front and the back.
// Depends on gfr_pkg for the frame item type and depth.
module gfr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  gfr_pkg::frame_item_t push_item,
  input  logic                 pop,
  output gfr_pkg::frame_item_t head_item,
  output logic                 empty,
  output logic                 full
);

  localparam int PW = $clog2(gfr_pkg::QUEUE_DEPTH);
  localparam int CW = $clog2(gfr_pkg::QUEUE_DEPTH + 1);

  gfr_pkg::frame_item_t entry_r [gfr_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_push, do_pop;

  assign empty     = (count_r == '0);
  assign full      = (count_r == CW'(gfr_pkg::QUEUE_DEPTH));
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_item = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + PW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + PW'(1);
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

// ===== hdl/gfr_back.sv =====
// Back part: tag check, field decode and the registered result stage.
// Depends on gfr_pkg; pops frames from gfr_queue.
module gfr_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  gfr_pkg::frame_item_t head_item,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [gfr_pkg::OUT_DATA_BITS-1:0] out_tdata
);

  logic        valid_r;
  logic [63:0] dec;
  logic [19:0] buttons_r;
  logic [7:0]  lsx_r, lsy_r, rsx_r, rsy_r;
  logic [63:0] raw_r;
  logic [15:0] err_r;

  assign pop = !empty && (!valid_r || out_tready);

  // frames without the expected tag decode as the neutral pad
  assign dec = (head_item.raw_frame[63:52] == gfr_pkg::FRAME_TAG) ?
               head_item.raw_frame : gfr_pkg::NEUTRAL_FRAME;

  always_ff @(posedge clk) begin
    if (pop) begin
      buttons_r <= dec[51:32];
      lsx_r     <= dec[7:0];
      lsy_r     <= dec[15:8];
      rsx_r     <= dec[23:16];
      rsy_r     <= dec[31:24];
      raw_r     <= head_item.raw_frame;
      err_r     <= head_item.error_tally;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {4'b0, err_r, raw_r, rsy_r, rsx_r, lsy_r, lsx_r, buttons_r};

endmodule

// ===== hdl/gamepad_frame_receiver.sv =====
// Gamepad frame receiver top level.
// Depends on gfr_pkg, gfr_front, gfr_queue and gfr_back.
//
// Input stream: one received serial byte per item on in_tdata. A 0xFD byte
// followed by a byte with upper nibble 0x4 opens a frame; the next 0xFD
// closes it and produces one result item on the output stream, carrying the
// decoded buttons and sticks, the raw 64-bit frame and the error tally.
// Bytes that do not close a frame produce no result.
// Throughput: one byte per cycle while in_tready is high; the front updates
// the frame store as each byte is taken.
// A closing byte writes its finished frame into the queue; from there it is
// loaded into the output register and shown on out_tvalid, waiting in the
// queue while the output register is held by a low out_tready.
// Reset clears the frame store, error tally and all framing state.
// When the receiver stalls out_tready, up to two finished frames wait in the
// queue besides the one in the output register; with the queue full,
// in_tready drops until a result is taken.
module gamepad_frame_receiver #(
  parameter int FRAME_BYTES = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] rx_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [19:0] button_bits, [27:20] left_stick_x, [35:28] left_stick_y,
  // [43:36] right_stick_x, [51:44] right_stick_y, [115:52] raw_frame,
  // [131:116] error_tally, [135:132] zero
  output logic [135:0] out_tdata
);

  gfr_pkg::frame_item_t push_item, head_item;
  logic push, pop, empty, full;

  assign in_tready = !full;

  gfr_front #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (in_tvalid && in_tready),
    .rx_byte    (in_tdata),
    .push       (push),
    .push_item  (push_item)
  );

  gfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .empty     (empty),
    .full      (full)
  );

  gfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_item  (head_item),
    .empty      (empty),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Testbench for gamepad_frame_receiver: a directed byte table, then random frames,
// broken headers and noise, checked against a behavioral frame predictor or typed-in frames.
// Depends on gfr_pkg and the receiver RTL.
module tb;

  localparam int N_RANDOM    = 1800;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_EVERY = 450;
  localparam int PRINT_MAX   = 40;

  // one decoded frame as it leaves the block
  typedef struct {
    logic [19:0] buttons;
    logic [7:0]  lx;
    logic [7:0]  ly;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [63:0] raw;
    logic [15:0] tally;
  } pad_frame_t;

  // one byte to send; known marks a closing byte whose frame is typed in here
  typedef struct {
    logic [7:0]  b;
    bit          known;
    logic [63:0] raw;
  } byte_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [135:0] out_tdata;

  always #5 clk = ~clk;

  gamepad_frame_receiver uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Directed bytes: empty frame after reset, full frame with extreme bytes,
  // bad headers (including 0xFD after 0xFD), overflow, short frame.
  byte_row_t dir_rows [28] = '{
    '{8'hFD, 1'b0, 64'h0}, '{8'h40, 1'b0, 64'h0},
    '{8'hFD, 1'b1, 64'hFD40_0000_0000_0000},
    '{8'h4F, 1'b0, 64'h0}, '{8'hFF, 1'b0, 64'h0}, '{8'h00, 1'b0, 64'h0},
    '{8'hFF, 1'b0, 64'h0}, '{8'h00, 1'b0, 64'h0}, '{8'hFF, 1'b0, 64'h0},
    '{8'h00, 1'b0, 64'h0},
    '{8'hFD, 1'b1, 64'hFD4F_FF00_FF00_FF00},
    '{8'h3F, 1'b0, 64'h0}, '{8'hFD, 1'b0, 64'h0}, '{8'hFD, 1'b0, 64'h0},
    '{8'hFD, 1'b0, 64'h0}, '{8'h41, 1'b0, 64'h0},
    '{8'h01, 1'b0, 64'h0}, '{8'h02, 1'b0, 64'h0}, '{8'h03, 1'b0, 64'h0},
    '{8'h04, 1'b0, 64'h0}, '{8'h05, 1'b0, 64'h0}, '{8'h06, 1'b0, 64'h0},
    '{8'h12, 1'b0, 64'h0},
    '{8'hFD, 1'b0, 64'h0}, '{8'h43, 1'b0, 64'h0}, '{8'hAB, 1'b0, 64'h0},
    '{8'hFD, 1'b0, 64'h0}, '{8'h00, 1'b0, 64'h0}
  };

  // predictor state
  logic       rcv_on;
  logic       sof_pending;
  logic [3:0] fill;
  logic [7:0] store [gfr_pkg::STORE_BYTES];
  logic [15:0] err_cnt;

  pad_frame_t frames_due [$];
  byte_row_t  sent_rows [$];

  int mismatches     = 0;
  int frames_checked = 0;
  int bytes_taken    = 0;
  int idle_cycles    = 0;

  task automatic report_mismatch(input string what);
    if (mismatches < PRINT_MAX)
      $display("tb: mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pad_frame_t decode_frame(input logic [63:0] raw,
                                              input logic [15:0] tally);
    pad_frame_t f;
    logic [63:0] dec;
    // the header nibble below the tag is not compared; a frame with another tag falls back to neutral
    dec = (raw[63:52] == gfr_pkg::FRAME_TAG) ? raw : gfr_pkg::NEUTRAL_FRAME;
    f.buttons = dec[51:32];
    f.lx      = dec[7:0];
    f.ly      = dec[15:8];
    f.rx      = dec[23:16];
    f.ry      = dec[31:24];
    f.raw     = raw;
    f.tally   = tally;
    return f;
  endfunction

  task automatic clear_predictor();
    rcv_on      = 1'b0;
    sof_pending = 1'b0;
    fill        = '0;
    err_cnt     = '0;
    foreach (store[i]) store[i] = '0;
  endtask

  task automatic bump_errors();
    if (err_cnt != gfr_pkg::ERR_MAX) err_cnt++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    store[3'd7 - fill[2:0]] = b;
    fill++;
  endtask

  task automatic rx_step(input logic [7:0] b, output bit emitted, output pad_frame_t f);
    logic [63:0] raw;
    emitted = 1'b0;
    f = '{default: '0};
    if (sof_pending) begin
      sof_pending = 1'b0;
      if (b[7:4] == gfr_pkg::HDR_NIBBLE) begin
        err_cnt = '0;
        fill    = '0;
        put_byte(gfr_pkg::SOF_BYTE);
        put_byte(b);
        rcv_on = 1'b1;
      end else begin
        bump_errors();
        fill   = '0;
        rcv_on = 1'b0;
      end
    end else begin
      // a closing 0xFD also opens the next header
      sof_pending = (b == gfr_pkg::SOF_BYTE);
      if (rcv_on) begin
        if (b == gfr_pkg::SOF_BYTE) begin
          rcv_on = 1'b0;
          raw = {store[7], store[6], store[5], store[4],
                 store[3], store[2], store[1], store[0]};
          f = decode_frame(raw, err_cnt);
          emitted = 1'b1;
        end else if (fill >= gfr_pkg::STORE_BYTES) begin
          bump_errors();
          rcv_on = 1'b0;
        end else begin
          put_byte(b);
        end
      end
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    byte_row_t  row;
    bit         emitted;
    pad_frame_t f;
    row = '{b: b, known: 1'b0, raw: '0};
    if (sent_rows.size() != 0) row = sent_rows.pop_front();
    rx_step(b, emitted, f);
    bytes_taken++;
    if (emitted) begin
      if (row.known) f = decode_frame(row.raw, 16'h0);
      frames_due.push_back(f);
    end else if (row.known) begin
      report_mismatch($sformatf("table expects a frame on byte %0d", bytes_taken));
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("frame %0d %s got %h want %h",
                                frames_checked, name, got, want));
  endtask

  task automatic check_frame(input logic [135:0] d);
    pad_frame_t e;
    if (frames_due.size() == 0) begin
      report_mismatch($sformatf("unexpected frame raw %h", d[115:52]));
    end else begin
      e = frames_due.pop_front();
      check_field("button_bits",   64'(d[19:0]),    64'(e.buttons));
      check_field("left_stick_x",  64'(d[27:20]),   64'(e.lx));
      check_field("left_stick_y",  64'(d[35:28]),   64'(e.ly));
      check_field("right_stick_x", 64'(d[43:36]),   64'(e.rx));
      check_field("right_stick_y", 64'(d[51:44]),   64'(e.ry));
      check_field("raw_frame",     d[115:52],       e.raw);
      check_field("error_tally",   64'(d[131:116]), 64'(e.tally));
    end
    frames_checked++;
  endtask

  // accepted items on both sides
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) check_frame(out_tdata);
      if (in_tvalid && in_tready) take_byte(in_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: timeout, nothing moved for %0d cycles", IDLE_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // result side back-pressure; every third window of ready_cycles stays ready once a pending hold ends
  int ready_hold   = 0;
  int ready_cycles = 0;
  always @(posedge clk) begin : ready_gen
    int len;
    ready_cycles++;
    if (ready_hold > 0) begin
      ready_hold--;
      out_tready <= 1'b0;
    end else if ((ready_cycles / 250) % 3 == 1) begin
      out_tready <= 1'b1;
    end else begin
      len = idle_len();
      out_tready <= (len == 0);
      ready_hold = (len > 0) ? len - 1 : 0;
    end
  end

  task automatic send_byte(input byte_row_t row, input int index);
    int gap;
    gap = idle_len();
    if ((index / 150) % 3 == 2) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sent_rows.push_back(row);
    in_tvalid <= 1'b1;
    in_tdata  <= row.b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (frames_due.size() != 0);
  endtask

  initial begin
    logic [7:0] plan [$];
    logic [7:0] b;
    logic [3:0] nib;
    int         pick;
    int         len;
    int         n;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    clear_predictor();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_byte(dir_rows[i], i);
    wait_drained();

    // mostly well-formed frames of random length and content
    while (plan.size() < N_RANDOM) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) begin
        nib = 4'($urandom_range(0, 15));
        plan.push_back(gfr_pkg::SOF_BYTE);
        plan.push_back({gfr_pkg::HDR_NIBBLE, nib});
        pick = $urandom_range(0, 99);
        if (pick < 70) len = $urandom_range(0, 6);
        else if (pick < 88) len = 6;
        else len = $urandom_range(7, 9);  // runs past the store
        repeat (len) begin
          b = 8'($urandom_range(0, 254));
          if (b >= gfr_pkg::SOF_BYTE) b++;
          plan.push_back(b);
        end
      end else if (pick < 90) begin
        n = $urandom_range(1, 4);
        repeat (n) begin
          b = 8'($urandom_range(0, 255));
          plan.push_back(b);
        end
      end else begin
        // header byte with any upper nibble but the good one
        nib = 4'($urandom_range(0, 14));
        if (nib >= gfr_pkg::HDR_NIBBLE) nib++;
        b[3:0] = 4'($urandom_range(0, 15));
        plan.push_back(gfr_pkg::SOF_BYTE);
        plan.push_back({nib, b[3:0]});
      end
    end
    plan.push_back(gfr_pkg::SOF_BYTE);

    foreach (plan[i]) begin
      if (i > 0 && i % DRAIN_EVERY == 0) wait_drained();
      send_byte('{b: plan[i], known: 1'b0, raw: 64'h0}, i);
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (frames_due.size() != 0)
      report_mismatch($sformatf("%0d frames never arrived", frames_due.size()));
    $display("tb: %0d bytes taken (%0d directed), %0d frames compared, %0d mismatches",
             bytes_taken, $size(dir_rows), frames_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/gfr_pkg.sv
hdl/gfr_front.sv
hdl/gfr_queue.sv
hdl/gfr_back.sv
hdl/gamepad_frame_receiver.sv
tb/tb.sv
